[hdl/line_follow_pwm_motor_drive_defines.svh]
// Assertion macros for the checker file lfpmd_checker.sv.
`ifndef LINE_FOLLOW_PWM_MOTOR_DRIVE_DEFINES_SVH
`define LINE_FOLLOW_PWM_MOTOR_DRIVE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define LFPMD_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define LFPMD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LFPMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lfpmd_pkg.sv]
package lfpmd_pkg;

    // Sample beat: one PWM tick with both sensor readings
    typedef struct packed {
        logic [7:0] left_sample;
        logic [7:0] right_sample;
    } sample_t;

    // Drive beat: pin levels after the tick
    typedef struct packed {
        logic left_forward;
        logic left_reverse;
        logic right_forward;
        logic right_reverse;
        logic running;
    } drive_t;

    // Motor direction codes; 3 also means off
    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    // Register indexes (word address)
    localparam logic [1:0] REG_DARK_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_DRIVE_DUTY     = 2'd1;
    localparam logic [1:0] REG_STOP_LIMIT     = 2'd2;
    localparam logic [1:0] REG_PERIOD_LAST    = 2'd3;

    // Reset values
    localparam logic [7:0] RST_DARK_THRESHOLD = 8'd112;
    localparam logic [6:0] RST_DRIVE_DUTY     = 7'd90;
    localparam logic [5:0] RST_STOP_LIMIT     = 6'd20;
    localparam logic [6:0] RST_PERIOD_LAST    = 7'd99;

    // Pin pair for a direction: bit 0 forward, bit 1 reverse
    function automatic logic [1:0] pair_for(input logic [1:0] dir);
        logic [1:0] pair;
        pair = 2'b00;
        if (dir == DIR_FWD)
        begin
            pair = 2'b01;
        end
        else if (dir == DIR_REV)
        begin
            pair = 2'b10;
        end
        return pair;
    endfunction

endpackage

[hdl/line_follow_pwm_motor_drive.sv]
// Channel  | Signals                            | Direction | Beat
// ---------+------------------------------------+-----------+--------------------------
// sample   | sample_valid, sample_ready, sample | in        | one PWM tick, two sensors
// drive    | drive_valid, drive_ready, drive    | out       | four pins and running
// config   | psel, penable, pwrite, paddr, ...  | in/out    | one 32-bit register
//
// One sample beat per cycle while ready; its drive beat is valid the cycle after acceptance.
// All state updates happen in the accept cycle through one level of compares
// and small adds; the drive output register decouples the two channels.
// sample_ready is low only while a drive beat is held by drive_ready low.
// rst_n is asynchronous, active low; registers return to their reset values
// and the first PWM period after reset has all pins off.
module line_follow_pwm_motor_drive
    import lfpmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        sample_valid,
    output logic        sample_ready,
    input  sample_t     sample,

    output logic        drive_valid,
    input  logic        drive_ready,
    output drive_t      drive,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [7:0] dark_threshold_reg;
    logic [6:0] drive_duty_reg;
    logic [5:0] stop_limit_reg;
    logic [6:0] period_last_reg;

    // Follower state
    logic [6:0] pwm_count_reg,  pwm_count_next;
    logic [1:0] left_dir_reg,   left_dir_next;
    logic [1:0] right_dir_reg,  right_dir_next;
    logic [6:0] left_duty_reg,  left_duty_next;
    logic [6:0] right_duty_reg, right_duty_next;
    logic [5:0] dark_count_reg, dark_count_next;
    logic       active_reg,     active_next;
    logic [3:0] pins_reg,       pins_next;   // [0] LF, [1] LR, [2] RF, [3] RR

    // Output stage
    logic       drive_valid_reg, drive_valid_next;
    drive_t     drive_reg;

    logic       sample_fire;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic       wrap;
    logic       left_dark;
    logic       right_dark;
    logic [6:0] dark_inc;
    logic       stop_hit;
    logic [3:0] pins_wrap;

    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];
    assign pready    = 1'b1;

    // ---------------- configuration port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_threshold_reg <= RST_DARK_THRESHOLD;
            drive_duty_reg     <= RST_DRIVE_DUTY;
            stop_limit_reg     <= RST_STOP_LIMIT;
            period_last_reg    <= RST_PERIOD_LAST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DARK_THRESHOLD: dark_threshold_reg <= pwdata[7:0];
                REG_DRIVE_DUTY:     drive_duty_reg     <= pwdata[6:0];
                REG_STOP_LIMIT:     stop_limit_reg     <= pwdata[5:0];
                REG_PERIOD_LAST:    period_last_reg    <= pwdata[6:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (cfg_index)
            REG_DARK_THRESHOLD: prdata = {24'd0, dark_threshold_reg};
            REG_DRIVE_DUTY:     prdata = {25'd0, drive_duty_reg};
            REG_STOP_LIMIT:     prdata = {26'd0, stop_limit_reg};
            REG_PERIOD_LAST:    prdata = {25'd0, period_last_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    // Accept whenever the output slot is empty or draining this cycle.
    assign sample_ready = !drive_valid_reg || drive_ready;
    assign sample_fire  = sample_valid && sample_ready;

    // ---------------- tick logic ----------------
    // Counter past period_last (possible after a register write) wraps too.
    assign wrap       = (pwm_count_reg >= period_last_reg);
    assign left_dark  = (sample.left_sample  >= dark_threshold_reg);
    assign right_dark = (sample.right_sample >= dark_threshold_reg);
    // 7-bit increment so a limit of 63 stops at 64 instead of wrapping
    assign dark_inc   = {1'b0, dark_count_reg} + 7'd1;
    assign stop_hit   = (dark_inc > {1'b0, stop_limit_reg});
    // Pins at wrap follow the directions held before this period's decision
    assign pins_wrap  = {pair_for(right_dir_reg), pair_for(left_dir_reg)};

    always_comb
    begin
        pwm_count_next  = pwm_count_reg;
        left_dir_next   = left_dir_reg;
        right_dir_next  = right_dir_reg;
        left_duty_next  = left_duty_reg;
        right_duty_next = right_duty_reg;
        dark_count_next = dark_count_reg;
        active_next     = active_reg;
        pins_next       = pins_reg;

        // Once stopped, nothing moves and the held pins are reported.
        if (active_reg)
        begin
            if (!wrap)
            begin
                pwm_count_next = pwm_count_reg + 7'd1;
            end
            else
            begin
                pwm_count_next = 7'd0;
                pins_next      = pins_wrap;
                if (left_dark && right_dark)
                begin
                    if (stop_hit)
                    begin
                        // permanent stop: all off, duties zero
                        dark_count_next = 6'd0;
                        active_next     = 1'b0;
                        left_dir_next   = DIR_OFF;
                        right_dir_next  = DIR_OFF;
                        left_duty_next  = 7'd0;
                        right_duty_next = 7'd0;
                    end
                    else
                    begin
                        dark_count_next = dark_inc[5:0];
                    end
                end
                else
                begin
                    left_dir_next   = DIR_FWD;
                    right_dir_next  = DIR_FWD;
                    // dark on one side: stop that side's motor to turn toward it
                    left_duty_next  = left_dark  ? 7'd0 : drive_duty_reg;
                    right_duty_next = right_dark ? 7'd0 : drive_duty_reg;
                end
            end

            // Duty compare uses the updated counter and duties
            if (pwm_count_next == left_duty_next)
            begin
                pins_next[1:0] = 2'b00;
            end
            if (pwm_count_next == right_duty_next)
            begin
                pins_next[3:2] = 2'b00;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_count_reg  <= 7'd0;
            left_dir_reg   <= DIR_FWD;
            right_dir_reg  <= DIR_FWD;
            left_duty_reg  <= RST_DRIVE_DUTY;
            right_duty_reg <= RST_DRIVE_DUTY;
            dark_count_reg <= 6'd0;
            active_reg     <= 1'b1;
            pins_reg       <= 4'd0;
        end
        else if (sample_fire)
        begin
            pwm_count_reg  <= pwm_count_next;
            left_dir_reg   <= left_dir_next;
            right_dir_reg  <= right_dir_next;
            left_duty_reg  <= left_duty_next;
            right_duty_reg <= right_duty_next;
            dark_count_reg <= dark_count_next;
            active_reg     <= active_next;
            pins_reg       <= pins_next;
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        drive_valid_next = drive_valid_reg;
        if (sample_fire)
        begin
            drive_valid_next = 1'b1;
        end
        else if (drive_ready)
        begin
            drive_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_valid_reg <= 1'b0;
        end
        else
        begin
            drive_valid_reg <= drive_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            drive_reg.left_forward  <= pins_next[0];
            drive_reg.left_reverse  <= pins_next[1];
            drive_reg.right_forward <= pins_next[2];
            drive_reg.right_reverse <= pins_next[3];
            drive_reg.running       <= active_next;
        end
    end

    assign drive_valid = drive_valid_reg;
    assign drive       = drive_reg;

endmodule

[hdl/lfpmd_checker.sv]
`include "line_follow_pwm_motor_drive_defines.svh"

module lfpmd_checker
    import lfpmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        drive_valid,
    input  logic        drive_ready,
    input  drive_t      drive
);

    // set once a stopped drive beat has been seen
    logic stopped_seen_reg;

    logic drive_stall;
    logic shoot_through;
    logic any_pin;
    logic stopped_beat;
    logic after_stop;

    assign drive_stall   = drive_valid && !drive_ready;
    assign shoot_through = (drive.left_forward && drive.left_reverse) ||
                           (drive.right_forward && drive.right_reverse);
    assign any_pin       = drive.left_forward || drive.left_reverse ||
                           drive.right_forward || drive.right_reverse;
    assign stopped_beat  = drive_valid && !drive.running;
    assign after_stop    = drive_valid && stopped_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_seen_reg <= 1'b0;
        end
        else if (drive_valid && drive_ready && !drive.running)
        begin
            stopped_seen_reg <= 1'b1;
        end
    end

    `LFPMD_ASSERT_NEXT(a_drive_hold, drive_stall, drive_valid && $stable(drive), "beat moved")
    `LFPMD_ASSERT_IMPL(a_no_shoot_through, drive_valid, !shoot_through, "bridge shoot-through")
    `LFPMD_ASSERT_IMPL(a_stopped_pins_off, stopped_beat, !any_pin, "pin on after stop")
    `LFPMD_ASSERT_IMPL(a_stop_is_final, after_stop, !drive.running, "running after stop")

endmodule

bind line_follow_pwm_motor_drive lfpmd_checker u_lfpmd_checker (.*);

[sim/line_follow_checker.sv]
`timescale 1ns / 1ps

// Watches the sample, drive and config ports, keeps its own copy of the
// line follower, and scores every drive beat against the oldest prediction.
module line_follow_checker
    import lfpmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        sample_valid,
    input  logic        sample_ready,
    input  sample_t     sample,

    input  logic        drive_valid,
    input  logic        drive_ready,
    input  drive_t      drive,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,

    output int          mismatch_count,
    output int          beats_in_flight
);

    // register copies
    logic [7:0] dark_level;
    logic [6:0] duty_cfg;
    logic [5:0] stop_cfg;
    logic [6:0] last_cfg;

    // follower state
    logic [6:0] pwm_pos;
    logic [1:0] dir_l;
    logic [1:0] dir_r;
    logic [6:0] duty_l;
    logic [6:0] duty_r;
    logic [5:0] dark_periods;
    logic       alive;
    logic [3:0] pins;         // {rr, rf, lr, lf}

    drive_t drive_expect_q [$];
    int     beat_no;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
        begin
            $display("[%0t] drive beat %0d: %s", $time, beat_no, msg);
        end
    endtask

    function automatic string pin_name(input int bit_idx);
        case (bit_idx)
            0: return "running";
            1: return "right_reverse";
            2: return "right_forward";
            3: return "left_reverse";
            default: return "left_forward";
        endcase
    endfunction

    // One PWM tick: wrap handling, steering, then duty cut-off.
    task automatic follow_tick(input sample_t s, output drive_t d);
        logic       ldark;
        logic       rdark;
        logic [6:0] next_dark;
        if (alive)
        begin
            if (pwm_pos < last_cfg)
            begin
                pwm_pos = pwm_pos + 7'd1;
            end
            else
            begin
                pwm_pos = '0;
                pins = {dir_r == DIR_REV, dir_r == DIR_FWD,
                        dir_l == DIR_REV, dir_l == DIR_FWD};
                ldark = s.left_sample >= dark_level;
                rdark = s.right_sample >= dark_level;
                if (ldark && rdark)
                begin
                    // 7-bit compare: a limit of 63 stops at 64, no wrap
                    next_dark = {1'b0, dark_periods} + 7'd1;
                    if (next_dark > {1'b0, stop_cfg})
                    begin
                        dark_periods = '0;
                        alive = 1'b0;
                        dir_l = DIR_OFF;
                        dir_r = DIR_OFF;
                        duty_l = '0;
                        duty_r = '0;
                    end
                    else
                    begin
                        dark_periods = next_dark[5:0];
                    end
                end
                else
                begin
                    dir_l = DIR_FWD;
                    dir_r = DIR_FWD;
                    duty_l = ldark ? 7'd0 : duty_cfg;
                    duty_r = rdark ? 7'd0 : duty_cfg;
                end
            end
            if (pwm_pos == duty_l)
            begin
                pins[1:0] = 2'b00;
            end
            if (pwm_pos == duty_r)
            begin
                pins[3:2] = 2'b00;
            end
        end
        d.left_forward  = pins[0];
        d.left_reverse  = pins[1];
        d.right_forward = pins[2];
        d.right_reverse = pins[3];
        d.running       = alive;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        drive_t want;
        drive_t got;
        if (!rst_n)
        begin
            dark_level = RST_DARK_THRESHOLD;
            duty_cfg = RST_DRIVE_DUTY;
            stop_cfg = RST_STOP_LIMIT;
            last_cfg = RST_PERIOD_LAST;
            pwm_pos = '0;
            dir_l = DIR_FWD;
            dir_r = DIR_FWD;
            duty_l = RST_DRIVE_DUTY;
            duty_r = RST_DRIVE_DUTY;
            dark_periods = '0;
            alive = 1'b1;
            pins = '0;
            drive_expect_q.delete();
            beats_in_flight = 0;
            mismatch_count = 0;
            beat_no = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_DARK_THRESHOLD: dark_level = pwdata[7:0];
                    REG_DRIVE_DUTY:     duty_cfg = pwdata[6:0];
                    REG_STOP_LIMIT:     stop_cfg = pwdata[5:0];
                    REG_PERIOD_LAST:    last_cfg = pwdata[6:0];
                    default: ;
                endcase
            end

            // drive side first: a beat leaving now belongs to an older sample
            if (drive_valid && drive_ready)
            begin
                got = drive;
                if (drive_expect_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat %b", got));
                end
                else
                begin
                    want = drive_expect_q.pop_front();
                    for (int i = 0; i < 5; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            report_mismatch($sformatf("%s got %b expected %b",
                                pin_name(i), got[i], want[i]));
                        end
                    end
                end
                beat_no++;
            end

            if (sample_valid && sample_ready)
            begin
                follow_tick(sample, want);
                drive_expect_q.push_back(want);
            end
            beats_in_flight = drive_expect_q.size();
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

// Line follower bench: stimulus and verdict live here, all prediction and
// scoring sit in line_follow_checker beside the DUT.
module tb;
    import lfpmd_pkg::*;

    // Longest legal quiet stretch is the forced drive hold-off (PRESSURE_CYCLES);
    // random stalls are shorter. Anything near this limit is a hang.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PRESSURE_CYCLES = 60;
    // Drive beat is valid the cycle after its sample is taken, so after the
    // last expected beat and a settle wait of SETTLE_CYCLES the block is surely idle.
    localparam int SETTLE_CYCLES   = 3;
    localparam int RANDOM_ITEMS    = 420;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_ready;
    sample_t     sample;
    logic        drive_valid;
    logic        drive_ready;
    drive_t      drive;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int beats_in_flight;

    // Stimulus-side view of where the PWM counter is and how many
    // both-dark wraps have been sent. Used to shape samples so the block
    // does not stop before the final phase, and to see when it stops.
    int pos_mirror;
    int last_mirror;
    int thr_mirror;
    int limit_mirror;
    int dark_wraps;
    bit halted;
    bit allow_stop;   // final phase: let the both-dark count run out
    bit steady;       // no gaps on either side
    bit hold_req;     // ask the drive side for a long hold-off

    line_follow_pwm_motor_drive u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .drive_valid  (drive_valid),
        .drive_ready  (drive_ready),
        .drive        (drive),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    line_follow_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .drive_valid     (drive_valid),
        .drive_ready     (drive_ready),
        .drive           (drive),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_count  (mismatch_count),
        .beats_in_flight (beats_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: any beat, any config access or reset counts as progress.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || psel || (sample_valid && sample_ready) ||
                (drive_valid && drive_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Drive-side sink. Mostly ready, short stalls, the odd long one, and one
    // forced hold-off on request so the output register fills and
    // sample_ready drops while the sender keeps pushing.
    initial
    begin : receiver
        int stall_left;
        int roll;
        drive_ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                drive_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                drive_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                drive_ready <= 1'b0;
                stall_left--;
            end
            else if (steady)
            begin
                drive_ready <= 1'b1;
            end
            else
            begin
                roll = $urandom_range(99, 0);
                if (roll < 70)
                begin
                    drive_ready <= 1'b1;
                end
                else if (roll < 92)
                begin
                    drive_ready <= 1'b0;
                    stall_left = $urandom_range(2, 0);
                end
                else
                begin
                    drive_ready <= 1'b0;
                    stall_left = $urandom_range(29, 7);
                end
            end
        end
    end

    // Two-phase config write; the register lands at the posedge inside the
    // access cycle (pready is tied high in the block). The bus then idles
    // so back-to-back writes each get their own setup cycle.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and wait for every predicted drive beat to come out.
    task automatic settle();
        sample_valid <= 1'b0;
        while (beats_in_flight != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input int thr, input int duty, input int limit,
                             input int per);
        settle();
        apb_write(REG_DARK_THRESHOLD, thr);
        apb_write(REG_DRIVE_DUTY, duty);
        apb_write(REG_STOP_LIMIT, limit);
        apb_write(REG_PERIOD_LAST, per);
        thr_mirror = thr;
        limit_mirror = limit;
        last_mirror = per;
    endtask

    // Sensor level on the chosen side of the current threshold.
    function automatic logic [7:0] level(input bit dark);
        if (dark || thr_mirror == 0)
        begin
            return 8'($urandom_range(255, thr_mirror));
        end
        return 8'($urandom_range(thr_mirror - 1, 0));
    endfunction

    // Mostly a random steering case with levels placed around the
    // threshold; some beats fully random so every sample bit toggles.
    function automatic sample_t shaped_pair();
        int roll;
        bit ldark;
        bit rdark;
        roll = $urandom_range(99, 0);
        if (roll < 20)
        begin
            return 16'($urandom_range(16'hFFFF, 0));
        end
        ldark = 1'($urandom_range(1, 0));
        rdark = 1'($urandom_range(1, 0));
        return {level(ldark), level(rdark)};
    endfunction

    // Offer one sample beat. Before it goes out, track the counter: on a
    // wrap tick a both-dark pair that would stop the block early gets its
    // right level pulled just under the threshold.
    task automatic send_item(input sample_t beat_in);
        sample_t beat;
        int      gap;
        int      roll;
        beat = beat_in;
        if (!halted)
        begin
            if (pos_mirror < last_mirror)
            begin
                pos_mirror++;
            end
            else
            begin
                pos_mirror = 0;
                if (beat.left_sample >= thr_mirror && beat.right_sample >= thr_mirror)
                begin
                    if (!allow_stop && thr_mirror > 0 && dark_wraps + 1 > limit_mirror)
                    begin
                        beat.right_sample = 8'(thr_mirror - 1);
                    end
                    if (beat.right_sample >= thr_mirror)
                    begin
                        dark_wraps++;
                        if (dark_wraps > limit_mirror)
                        begin
                            halted = 1'b1;
                        end
                    end
                end
            end
        end

        // sender gap: mostly none, some short, a few long
        gap = 0;
        if (!steady)
        begin
            roll = $urandom_range(99, 0);
            if (roll >= 92)
            begin
                gap = $urandom_range(25, 6);
            end
            else if (roll >= 65)
            begin
                gap = $urandom_range(3, 1);
            end
        end
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample <= beat;
        sample_valid <= 1'b1;
        do @(posedge clk); while (!sample_ready);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        sample_t wrap_beats [5];
        int      per;
        int      duty;
        int      thr;
        int      limit;
        int      items;
        int      sent;
        int      phase;
        int      roll;

        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pos_mirror = 0;
        last_mirror = RST_PERIOD_LAST;
        thr_mirror = RST_DARK_THRESHOLD;
        limit_mirror = RST_STOP_LIMIT;
        dark_wraps = 0;
        halted = 1'b0;
        allow_stop = 1'b0;
        steady = 1'b0;
        hold_req = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First period after reset: pins must stay off, counter climbs to 6.
        repeat (6) send_item(shaped_pair());

        // Directed: period_last 3 is below the counter, so the first tick
        // wraps at once. Duty 99 sits above the period, pins stay on.
        // Wrap ticks carry: both dark, left dark at threshold, right dark at
        // threshold, both just below, both exactly at threshold.
        wrap_beats[0] = {8'd255, 8'd255};
        wrap_beats[1] = {8'd128, 8'd0};
        wrap_beats[2] = {8'd0, 8'd128};
        wrap_beats[3] = {8'd127, 8'd127};
        wrap_beats[4] = {8'd128, 8'd128};
        configure(128, 99, 63, 3);
        for (int n = 0; n < 20; n++)
        begin
            if (n % 4 == 0)
            begin
                send_item(wrap_beats[n / 4]);
            end
            else
            begin
                send_item((n % 2) ? {8'hFF, 8'h00} : {8'h00, 8'hFF});
            end
        end

        // Top threshold, period_last 1, zero stop limit; both-dark is held
        // off here so the zero limit does not end the run.
        configure(255, 1, 0, 1);
        send_item({8'd255, 8'd255});
        send_item({8'd255, 8'd255});
        send_item({8'd255, 8'd0});
        send_item({8'd0, 8'd255});
        send_item({8'd254, 8'd254});
        send_item({8'd0, 8'd0});

        // Random phases. Phase 1 carries the long drive hold-off with the
        // sender running flat out; phase 2 is the one long 127 period.
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase == 2)
            begin
                per = 127;
            end
            else
            begin
                per = ($urandom_range(9, 0) < 7) ? $urandom_range(7, 1)
                                                 : $urandom_range(20, 8);
            end
            roll = $urandom_range(99, 0);
            if (roll < 25)
            begin
                duty = 0;
            end
            else if (roll < 40)
            begin
                duty = per + $urandom_range(3, 0);
            end
            else if (roll < 50)
            begin
                duty = 99;
            end
            else
            begin
                duty = $urandom_range(per, 0);
            end
            if (duty > 99)
            begin
                duty = 99;
            end
            roll = $urandom_range(99, 0);
            thr = (roll < 10) ? 255 : (roll < 20) ? 1 : $urandom_range(240, 16);
            roll = $urandom_range(99, 0);
            limit = (roll < 65) ? 63 : (roll < 75) ? 0 : $urandom_range(63, 0);
            items = (phase == 2) ? 130 : $urandom_range(50, 20);

            steady = (phase == 1) || ($urandom_range(4, 0) == 0);
            configure(thr, duty, limit, per);
            if (phase == 1)
            begin
                hold_req = 1'b1;
            end
            repeat (items) send_item(shaped_pair());
            sent += items;
            phase++;
        end

        // Final: everything is dark, limit 63, so the count climbs to 64
        // and the block stops for good on that wrap tick.
        steady = 1'b0;
        allow_stop = 1'b1;
        configure(0, $urandom_range(99, 0), 63, 1);
        while (!halted) send_item(shaped_pair());
        repeat (4) send_item(shaped_pair());

        // Writes after the stop are stored but change nothing visible.
        configure(200, 5, 10, 2);
        repeat (8) send_item(shaped_pair());

        settle();
        if (mismatch_count == 0 && beats_in_flight == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/lfpmd_pkg.sv
hdl/line_follow_pwm_motor_drive.sv
hdl/lfpmd_checker.sv
sim/line_follow_checker.sv
sim/tb.sv
